FILE: rtl/core/hcr_pkg.sv
`timescale 1ns / 1ps

package hcr_pkg;

    // Field widths
    localparam int CHAN_NUM  = 3;
    localparam int VAL_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int EN_W      = 3;
    localparam int IDX_W     = 3;

    // Span (ceiling - floor) needs one bit more than a sample
    localparam int DEN_W     = VAL_W + 1;
    // 255 * span shifted by up to seven places, plus headroom
    localparam int REM_W     = VAL_W + BYTE_W + 1;

    // One quotient bit per divide stage
    localparam int DIV_STEPS = BYTE_W;
    // Prepare stage, multiply stage, divide stages
    localparam int PIPE_DEPTH = DIV_STEPS + 2;

    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_FLOOR_RED      = 3'd0,
        REG_CEIL_RED       = 3'd1,
        REG_FLOOR_GREEN    = 3'd2,
        REG_CEIL_GREEN     = 3'd3,
        REG_FLOOR_BLUE     = 3'd4,
        REG_CEIL_BLUE      = 3'd5,
        REG_CHANNEL_ENABLE = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic              zero;
        logic              sat;
        logic [DEN_W-1:0]  den;
        logic [REM_W-1:0]  rem;
        logic [BYTE_W-1:0] quo;
    } chan_t;

    typedef struct packed {
        chan_t [CHAN_NUM-1:0] ch;
        logic                 alpha_on;
        logic                 last;
    } beat_t;

endpackage

FILE: rtl/core/heatmap_channel_to_rgba_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// pixel     pixel_valid / pixel_ready    value_red/green/blue, bad_red/green/blue, last_pixel
// rgba      rgba_valid / rgba_ready      red_byte, green_byte, blue_byte, alpha_byte, frame_end
// config    cfg_write (no handshake)     cfg_index, cfg_data
//
// One pixel per cycle sustained while rgba_ready is held high; from pixel beat to rgba beat
// a beat passes the prepare and multiply registers, the eight divide stages (one quotient
// bit each) and the output register.
// rst_n clears the valid bits and loads the register reset values at once; no sweep.
// Each stage holds its beat only while the stage after it is full and stalled, so
// bubbles close up and a stall on rgba loses and repeats nothing.

module heatmap_channel_to_rgba_unit #(
    parameter int FRACTION_BITS = hcr_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write,
    input  logic [hcr_pkg::IDX_W-1:0]        cfg_index,
    input  logic [hcr_pkg::VAL_W-1:0]        cfg_data,

    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic signed [hcr_pkg::VAL_W-1:0] value_red,
    input  logic signed [hcr_pkg::VAL_W-1:0] value_green,
    input  logic signed [hcr_pkg::VAL_W-1:0] value_blue,
    input  logic                             bad_red,
    input  logic                             bad_green,
    input  logic                             bad_blue,
    input  logic                             last_pixel,

    output logic                             rgba_valid,
    input  logic                             rgba_ready,
    output logic [hcr_pkg::BYTE_W-1:0]       red_byte,
    output logic [hcr_pkg::BYTE_W-1:0]       green_byte,
    output logic [hcr_pkg::BYTE_W-1:0]       blue_byte,
    output logic [hcr_pkg::BYTE_W-1:0]       alpha_byte,
    output logic                             frame_end
);

    localparam int CHN   = hcr_pkg::CHAN_NUM;
    localparam int VW    = hcr_pkg::VAL_W;
    localparam int BW    = hcr_pkg::BYTE_W;
    localparam int DW    = hcr_pkg::DEN_W;
    localparam int RW    = hcr_pkg::REM_W;
    localparam int DEPTH = hcr_pkg::PIPE_DEPTH;
    localparam int STEPS = hcr_pkg::DIV_STEPS;

    // Ceiling reset value is 1.0 in the fixed-point format
    localparam logic [VW-1:0] CEIL_RESET = VW'(64'd1 << FRACTION_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [VW-1:0]         floor_reg [CHN];
    logic signed [VW-1:0]         ceil_reg  [CHN];
    logic [hcr_pkg::EN_W-1:0]     enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHN; c++)
            begin
                floor_reg[c] <= '0;
                ceil_reg[c]  <= CEIL_RESET;
            end
            enable_reg <= '1;
        end
        else if (cfg_write)
        begin
            case (hcr_pkg::reg_index_t'(cfg_index))
                hcr_pkg::REG_FLOOR_RED:      floor_reg[0] <= cfg_data;
                hcr_pkg::REG_CEIL_RED:       ceil_reg[0]  <= cfg_data;
                hcr_pkg::REG_FLOOR_GREEN:    floor_reg[1] <= cfg_data;
                hcr_pkg::REG_CEIL_GREEN:     ceil_reg[1]  <= cfg_data;
                hcr_pkg::REG_FLOOR_BLUE:     floor_reg[2] <= cfg_data;
                hcr_pkg::REG_CEIL_BLUE:      ceil_reg[2]  <= cfg_data;
                hcr_pkg::REG_CHANNEL_ENABLE: enable_reg   <= cfg_data[hcr_pkg::EN_W-1:0];
                default:                     ;  // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers and ready chain
    // ------------------------------------------------------------------
    logic                 valid_reg [DEPTH];
    hcr_pkg::beat_t       data_reg  [DEPTH];
    hcr_pkg::beat_t       data_next [DEPTH];
    logic                 stage_ready [DEPTH+1];

    logic                 out_valid_reg;
    logic [BW-1:0]        red_reg, green_reg, blue_reg, alpha_reg;
    logic                 last_reg;
    logic [BW-1:0]        byte_next [CHN];

    // A stage may load when it is empty or its beat moves on this cycle
    always_comb
    begin
        stage_ready[DEPTH] = !out_valid_reg || rgba_ready;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign pixel_ready = stage_ready[0];

    logic signed [VW-1:0] in_value [CHN];
    logic                 in_bad   [CHN];
    logic signed [DW-1:0] diff_lo  [CHN];
    logic signed [DW-1:0] diff_hi  [CHN];

    assign in_value[0] = value_red;
    assign in_value[1] = value_green;
    assign in_value[2] = value_blue;
    assign in_bad[0]   = bad_red;
    assign in_bad[1]   = bad_green;
    assign in_bad[2]   = bad_blue;

    always_comb
    begin
        logic [RW-1:0] shifted;
        shifted = '0;

        // --------------------------------------------------------------
        // Stage 0: range checks, offset from floor and span
        // --------------------------------------------------------------
        for (int c = 0; c < CHN; c++)
        begin
            diff_lo[c] = {in_value[c][VW-1], in_value[c]} - {floor_reg[c][VW-1], floor_reg[c]};
            diff_hi[c] = {ceil_reg[c][VW-1], ceil_reg[c]} - {floor_reg[c][VW-1], floor_reg[c]};
            data_next[0].ch[c].zero = !enable_reg[c] || in_bad[c] || (diff_lo[c] <= 0);
            data_next[0].ch[c].sat  = (in_value[c] >= ceil_reg[c]);
            data_next[0].ch[c].den  = diff_hi[c];
            // Offset lies below the span whenever it is used, so 32 bits hold it
            data_next[0].ch[c].rem  = RW'(diff_lo[c][VW-1:0]);
            data_next[0].ch[c].quo  = '0;
        end
        data_next[0].alpha_on = |enable_reg;
        data_next[0].last     = last_pixel;

        // --------------------------------------------------------------
        // Stage 1: scale the offset by 255 as (x << 8) - x
        // --------------------------------------------------------------
        data_next[1] = data_reg[0];
        for (int c = 0; c < CHN; c++)
        begin
            data_next[1].ch[c].rem = (data_reg[0].ch[c].rem << BW) - data_reg[0].ch[c].rem;
        end

        // --------------------------------------------------------------
        // Stages 2..: restoring divide, most significant quotient bit first
        // --------------------------------------------------------------
        for (int j = 2; j < DEPTH; j++)
        begin
            data_next[j] = data_reg[j-1];
            for (int c = 0; c < CHN; c++)
            begin
                shifted = RW'(data_reg[j-1].ch[c].den) << (STEPS - 1 - (j - 2));
                if (data_reg[j-1].ch[c].rem >= shifted)
                begin
                    data_next[j].ch[c].rem = data_reg[j-1].ch[c].rem - shifted;
                    data_next[j].ch[c].quo[STEPS-1-(j-2)] = 1'b1;
                end
            end
        end
    end

    // Final byte: clamp cases override the quotient
    always_comb
    begin
        for (int c = 0; c < CHN; c++)
        begin
            if (data_reg[DEPTH-1].ch[c].zero)
                byte_next[c] = '0;
            else if (data_reg[DEPTH-1].ch[c].sat)
                byte_next[c] = hcr_pkg::BYTE_MAX;
            else
                byte_next[c] = data_reg[DEPTH-1].ch[c].quo;
        end
    end

    // Valid bits: advance when the next slot frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_ready[0])
                valid_reg[0] <= pixel_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                if (stage_ready[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
            if (stage_ready[DEPTH])
                out_valid_reg <= valid_reg[DEPTH-1];
        end
    end

    // Payload: load with the valid bit, hold otherwise
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (stage_ready[i])
                data_reg[i] <= data_next[i];
        end
        if (stage_ready[DEPTH])
        begin
            red_reg   <= byte_next[0];
            green_reg <= byte_next[1];
            blue_reg  <= byte_next[2];
            alpha_reg <= data_reg[DEPTH-1].alpha_on ? hcr_pkg::BYTE_MAX : '0;
            last_reg  <= data_reg[DEPTH-1].last;
        end
    end

    assign rgba_valid = out_valid_reg;
    assign red_byte   = red_reg;
    assign green_byte = green_reg;
    assign blue_byte  = blue_reg;
    assign alpha_byte = alpha_reg;
    assign frame_end  = last_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import hcr_pkg::*;

    // Pipeline depth plus margin. Wait this long after the last rgba beat
    // before touching the registers or ending the run.
    localparam int SETTLE_CYCLES = 16;
    // Cycles without any beat on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    localparam int GAP_MAX       = 17;
    localparam int RAND_PHASES   = 10;
    localparam int RAND_PIXELS   = 115;
    localparam int REPORT_MAX    = 10;

    localparam longint SAMPLE_MIN = -64'sd2147483648;
    localparam longint SAMPLE_MAX = 64'sd2147483647;

    localparam reg_index_t FLOOR_REG [CHAN_NUM] =
        '{REG_FLOOR_RED, REG_FLOOR_GREEN, REG_FLOOR_BLUE};
    localparam reg_index_t CEIL_REG [CHAN_NUM] =
        '{REG_CEIL_RED, REG_CEIL_GREEN, REG_CEIL_BLUE};

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic              frame_end;
    } rgba_beat_t;

    // Expected-colour tracker: its own copy of the floor, ceiling and
    // enable registers, and the queue of rgba beats still owed by the block.
    class rgba_tracker;
        logic signed [VAL_W-1:0] lo_reg [CHAN_NUM];
        logic signed [VAL_W-1:0] hi_reg [CHAN_NUM];
        logic [EN_W-1:0]         chan_on;
        rgba_beat_t              pending_rgba [$];
        int                      mismatches;
        int                      checked;

        function new();
            for (int c = 0; c < CHAN_NUM; c++)
            begin
                lo_reg[c] = '0;
                hi_reg[c] = VAL_W'(1) << FRACTION_BITS_DEF;
            end
            chan_on    = '1;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [VAL_W-1:0] data);
            case (idx)
                REG_FLOOR_RED:      lo_reg[0] = data;
                REG_CEIL_RED:       hi_reg[0] = data;
                REG_FLOOR_GREEN:    lo_reg[1] = data;
                REG_CEIL_GREEN:     hi_reg[1] = data;
                REG_FLOOR_BLUE:     lo_reg[2] = data;
                REG_CEIL_BLUE:      hi_reg[2] = data;
                REG_CHANNEL_ENABLE: chan_on = data[EN_W-1:0];
                default:            ;
            endcase
        endfunction

        // Linear stretch of one sample between floor and ceiling, clamped to a byte
        function logic [BYTE_W-1:0] scale_channel(logic on, logic bad,
                                                  logic signed [VAL_W-1:0] v,
                                                  logic signed [VAL_W-1:0] lo,
                                                  logic signed [VAL_W-1:0] hi);
            longint part;
            longint span;
            if (!on || bad || v <= lo)
                return '0;
            if (v >= hi)
                return BYTE_MAX;
            part = longint'(v) - longint'(lo);
            span = longint'(hi) - longint'(lo);
            return BYTE_W'((part * longint'(BYTE_MAX)) / span);
        endfunction

        function void note_pixel(logic signed [VAL_W-1:0] r, logic signed [VAL_W-1:0] g,
                                 logic signed [VAL_W-1:0] b, logic [CHAN_NUM-1:0] bad,
                                 logic last);
            rgba_beat_t want;
            want.red       = scale_channel(chan_on[0], bad[0], r, lo_reg[0], hi_reg[0]);
            want.green     = scale_channel(chan_on[1], bad[1], g, lo_reg[1], hi_reg[1]);
            want.blue      = scale_channel(chan_on[2], bad[2], b, lo_reg[2], hi_reg[2]);
            want.alpha     = (chan_on != '0) ? BYTE_MAX : '0;
            want.frame_end = last;
            pending_rgba.push_back(want);
        endfunction

        function void check_rgba(rgba_beat_t got);
            rgba_beat_t want;
            checked++;
            if (pending_rgba.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("rgba beat with nothing owed: r=%0d g=%0d b=%0d a=%0d end=%0b",
                             got.red, got.green, got.blue, got.alpha, got.frame_end);
                return;
            end
            want = pending_rgba.pop_front();
            if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
                got.alpha != want.alpha || got.frame_end != want.frame_end)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"rgba mismatch: want r=%0d g=%0d b=%0d a=%0d end=%0b,",
                              " got r=%0d g=%0d b=%0d a=%0d end=%0b"},
                             want.red, want.green, want.blue, want.alpha, want.frame_end,
                             got.red, got.green, got.blue, got.alpha, got.frame_end);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cfg_write = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [VAL_W-1:0]         cfg_data = '0;

    logic                     pixel_valid = 1'b0;
    logic                     pixel_ready;
    logic signed [VAL_W-1:0]  value_red = '0;
    logic signed [VAL_W-1:0]  value_green = '0;
    logic signed [VAL_W-1:0]  value_blue = '0;
    logic                     bad_red = 1'b0;
    logic                     bad_green = 1'b0;
    logic                     bad_blue = 1'b0;
    logic                     last_pixel = 1'b0;

    logic                     rgba_valid;
    logic                     rgba_ready = 1'b0;
    logic [BYTE_W-1:0]        red_byte;
    logic [BYTE_W-1:0]        green_byte;
    logic [BYTE_W-1:0]        blue_byte;
    logic [BYTE_W-1:0]        alpha_byte;
    logic                     frame_end;

    rgba_tracker tracker = new();

    // Register settings of the current phase, and the idle depth of each side
    logic signed [VAL_W-1:0]  range_lo [CHAN_NUM];
    logic signed [VAL_W-1:0]  range_hi [CHAN_NUM];
    logic [EN_W-1:0]          chan_mask;
    int                       src_gap_max = 0;
    int                       sink_gap_max = 0;
    int                       pixels_sent = 0;
    int                       settings_used = 1;

    heatmap_channel_to_rgba_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .value_red   (value_red),
        .value_green (value_green),
        .value_blue  (value_blue),
        .bad_red     (bad_red),
        .bad_green   (bad_green),
        .bad_blue    (bad_blue),
        .last_pixel  (last_pixel),
        .rgba_valid  (rgba_valid),
        .rgba_ready  (rgba_ready),
        .red_byte    (red_byte),
        .green_byte  (green_byte),
        .blue_byte   (blue_byte),
        .alpha_byte  (alpha_byte),
        .frame_end   (frame_end)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Drive one register per falling edge; the caller lowers cfg_write afterwards.
    task automatic put_reg(reg_index_t idx, logic [VAL_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Load the whole register file from the phase settings. Call only when idle.
    task automatic program_regs();
        for (int c = 0; c < CHAN_NUM; c++)
        begin
            put_reg(FLOOR_REG[c], range_lo[c]);
            put_reg(CEIL_REG[c], range_hi[c]);
        end
        put_reg(REG_CHANNEL_ENABLE, {{(VAL_W-EN_W){1'b0}}, chan_mask});
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Drop pixel valid, hold until every owed rgba beat has arrived,
    // then let the pipe drain.
    task automatic settle();
        pixel_valid <= 1'b0;
        while (tracker.pending_rgba.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Offer one pixel beat after a random gap and hold it until taken.
    // Entered and left on a falling edge; valid stays high across back-to-back beats.
    task automatic send_pixel(logic signed [VAL_W-1:0] r, logic signed [VAL_W-1:0] g,
                              logic signed [VAL_W-1:0] b, logic [CHAN_NUM-1:0] bad,
                              logic last);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        value_red   <= r;
        value_green <= g;
        value_blue  <= b;
        bad_red     <= bad[0];
        bad_green   <= bad[1];
        bad_blue    <= bad[2];
        last_pixel  <= last;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_ready);
        tracker.note_pixel(r, g, b, bad, last);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Pick a floor and ceiling for one channel: full range, empty range,
    // inverted range, arbitrary pair, narrow span, or the reset pair.
    task automatic pick_range(int c);
        longint lo;
        longint hi;
        lo = longint'($signed($urandom));
        hi = longint'($signed($urandom));
        case ($urandom_range(0, 5))
            0:
            begin
                lo = SAMPLE_MIN;
                hi = SAMPLE_MAX;
            end
            1: hi = lo;
            2:
            begin
                lo = hi + longint'($urandom_range(1, 1000));
                if (lo > SAMPLE_MAX)
                begin
                    lo = SAMPLE_MAX;
                    hi = SAMPLE_MAX - 5;
                end
            end
            3: ;
            4:
            begin
                hi = lo + longint'($urandom_range(1, 600));
                if (hi > SAMPLE_MAX)
                begin
                    hi = SAMPLE_MAX;
                    lo = SAMPLE_MAX - 300;
                end
            end
            default:
            begin
                lo = 0;
                hi = longint'(1) << FRACTION_BITS_DEF;
            end
        endcase
        range_lo[c] = lo[VAL_W-1:0];
        range_hi[c] = hi[VAL_W-1:0];
    endtask

    // Draw a sample for one channel, biased into and around the live range
    function automatic logic signed [VAL_W-1:0] pick_sample(int c);
        longint    lo;
        longint    hi;
        longint    v;
        bit [63:0] r;
        lo = longint'(range_lo[c]);
        hi = longint'(range_hi[c]);
        r  = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1: v = longint'($signed(r[31:0]));
            2:    v = lo + longint'($urandom_range(0, 6)) - 3;
            3:    v = hi + longint'($urandom_range(0, 6)) - 3;
            4:    v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            default:
                if (hi > lo)
                    v = lo + longint'(r % 64'(hi - lo + 1));
                else
                    v = hi + longint'($urandom_range(0, 2000)) - 1000;
        endcase
        return v[VAL_W-1:0];
    endfunction

    // Sink: drop ready for a random number of cycles before each beat,
    // then hold it high until the beat is taken.
    initial
    begin : rgba_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, sink_gap_max);
            if (gap > 0)
            begin
                rgba_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rgba_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rgba_valid && rgba_ready));
        end
    end

    // Check every rgba beat against the oldest owed colour
    always @(posedge clk)
    begin : rgba_monitor
        rgba_beat_t got;
        if (rst_n && rgba_valid && rgba_ready)
        begin
            got.red       = red_byte;
            got.green     = green_byte;
            got.blue      = blue_byte;
            got.alpha     = alpha_byte;
            got.frame_end = frame_end;
            tracker.check_rgba(got);
        end
    end

    // Abandon the run if neither channel moves a beat for too long
    initial
    begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && pixel_ready) || (rgba_valid && rgba_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [CHAN_NUM-1:0] bad;
        int                  failures;

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values: floor 0, ceiling 1.0, all channels on.
        // Walk the edges of the stretch and the bad and last flags.
        send_pixel(0, 0, 0, 3'b000, 1'b0);
        send_pixel(32'sd65536, 32'sd65536, 32'sd65536, 3'b000, 1'b0);
        send_pixel(32'sd32768, 32'sd65535, 32'sd1, 3'b000, 1'b0);
        send_pixel(32'sd257, 32'sd256, 32'sd65537, 3'b000, 1'b0);
        send_pixel(-32'sd1, 32'sd2147483647, -32'sd2147483648, 3'b000, 1'b0);
        send_pixel(32'sd32768, 32'sd32768, 32'sd32768, 3'b001, 1'b0);
        send_pixel(32'sd32768, 32'sd32768, 32'sd32768, 3'b010, 1'b0);
        send_pixel(32'sd32768, 32'sd32768, 32'sd32768, 3'b100, 1'b1);
        send_pixel(32'sd65536, 32'sd65536, 32'sd65536, 3'b111, 1'b1);
        send_pixel(-32'sd2147483648, -32'sd1, 32'sd2147483647, 3'b000, 1'b1);
        settle();

        // Full-width span on red, empty range on green, inverted range on blue
        range_lo[0] = -32'sd2147483648;
        range_hi[0] = 32'sd2147483647;
        range_lo[1] = 32'sd100;
        range_hi[1] = 32'sd100;
        range_lo[2] = 32'sd500;
        range_hi[2] = -32'sd500;
        chan_mask   = 3'b111;
        program_regs();
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
        send_pixel(-32'sd2147483647, 32'sd100, 32'sd500, 3'b000, 1'b0);
        send_pixel(32'sd2147483646, 32'sd101, 32'sd501, 3'b000, 1'b0);
        send_pixel(0, 32'sd99, 0, 3'b000, 1'b0);
        send_pixel(-32'sd2147483648, 32'sd2147483647, -32'sd600, 3'b000, 1'b1);
        send_pixel(32'sd2147483647, -32'sd2147483648, 32'sd2147483647, 3'b000, 1'b0);
        settle();

        // All channels off: every byte and alpha go to zero
        chan_mask = 3'b000;
        program_regs();
        send_pixel(32'sd2147483647, 32'sd2147483647, 32'sd2147483647, 3'b000, 1'b0);
        send_pixel(0, 32'sd100, 32'sd400, 3'b000, 1'b1);
        settle();

        // Green alone
        chan_mask = 3'b010;
        program_regs();
        send_pixel(32'sd2147483647, 32'sd2147483647, -32'sd2147483648, 3'b000, 1'b0);
        send_pixel(32'sd2147483647, 32'sd100, -32'sd2147483648, 3'b000, 1'b0);
        settle();

        // Random phases: fresh registers and idle depths each time.
        // The first forces full-range spans with all channels on, the second all off.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            for (int c = 0; c < CHAN_NUM; c++)
            begin
                pick_range(c);
                if (p == 0)
                begin
                    range_lo[c] = -32'sd2147483648;
                    range_hi[c] = 32'sd2147483647;
                end
            end
            chan_mask    = (p == 0) ? 3'b111 : (p == 1) ? 3'b000 : EN_W'($urandom_range(0, 7));
            src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            program_regs();
            for (int n = 0; n < RAND_PIXELS; n++)
            begin
                bad = {($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0),
                       ($urandom_range(0, 7) == 0)};
                send_pixel(pick_sample(0), pick_sample(1), pick_sample(2), bad,
                           ($urandom_range(0, 15) == 0));
            end
            settle();
        end

        pixel_valid <= 1'b0;
        settle();

        failures = tracker.mismatches + tracker.pending_rgba.size();
        $display("Sent %0d pixels and checked %0d rgba beats across %0d register settings.",
                 pixels_sent, tracker.checked, settings_used);
        $display("Mismatches %0d, colours still owed %0d.",
                 tracker.mismatches, tracker.pending_rgba.size());
        if (failures == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
